/* src/owm_pkg.sv */
// ----------------------------------------------------------------------------
// owm_pkg: shared types and constants of the 1-Wire bus master
// Holds the phase and command codes, the configuration record and the timer
// sizing that the register file and the sequencer both use.
// ----------------------------------------------------------------------------
package owm_pkg;

  // Width of the slot timer. A phase ends at the latest when the timer
  // reaches its largest value.
  localparam int TIMER_BITS = 10;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  // Widest configuration length, and a compare width that holds both it and
  // the incremented timer.
  localparam int LEN_BITS = 10;
  localparam int CMP_W    = (TIMER_BITS + 1 > LEN_BITS) ? TIMER_BITS + 1 : LEN_BITS;

  // Ticks between releasing the line and polling for presence.
  localparam logic [LEN_BITS-1:0] RELEASE_WAIT = LEN_BITS'(2);

  // Configuration port geometry.
  localparam int NUM_REGS  = 8;
  localparam int ADDR_BITS = 5;

  typedef enum logic [2:0] {
    REG_RESET_LOW   = 3'd0,
    REG_PRES_POLL   = 3'd1,
    REG_WR_ONE_LOW  = 3'd2,
    REG_WR_ZERO_LOW = 3'd3,
    REG_WR_SLOT     = 3'd4,
    REG_RD_LOW      = 3'd5,
    REG_RD_SAMPLE   = 3'd6,
    REG_RD_SLOT     = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_RESET = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_RLOW  = 3'd1,
    PH_RGAP  = 3'd2,
    PH_RPOLL = 3'd3,
    PH_RHOLD = 3'd4,
    PH_WRITE = 3'd5,
    PH_READ  = 3'd6
  } phase_t;

  typedef struct packed {
    logic [9:0] reset_low_ticks;
    logic [9:0] presence_poll_ticks;
    logic [7:0] write_one_low_ticks;
    logic [7:0] write_zero_low_ticks;
    logic [7:0] write_slot_ticks;
    logic [7:0] read_low_ticks;
    logic [7:0] read_sample_tick;
    logic [7:0] read_slot_ticks;
  } cfg_t;

endpackage

/* src/owm_regs.sv */
// ----------------------------------------------------------------------------
// owm_regs: configuration register file of the 1-Wire bus master
// APB-style write and read access to the eight timing registers.
// ----------------------------------------------------------------------------
module owm_regs
  import owm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks      <= 10'd480;
      cfg.presence_poll_ticks  <= 10'd100;
      cfg.write_one_low_ticks  <= 8'd6;
      cfg.write_zero_low_ticks <= 8'd60;
      cfg.write_slot_ticks     <= 8'd70;
      cfg.read_low_ticks       <= 8'd2;
      cfg.read_sample_tick     <= 8'd7;
      cfg.read_slot_ticks      <= 8'd87;
    end else if (wr_en) begin
      case (idx)
        REG_RESET_LOW:   cfg.reset_low_ticks      <= pwdata[9:0];
        REG_PRES_POLL:   cfg.presence_poll_ticks  <= pwdata[9:0];
        REG_WR_ONE_LOW:  cfg.write_one_low_ticks  <= pwdata[7:0];
        REG_WR_ZERO_LOW: cfg.write_zero_low_ticks <= pwdata[7:0];
        REG_WR_SLOT:     cfg.write_slot_ticks     <= pwdata[7:0];
        REG_RD_LOW:      cfg.read_low_ticks       <= pwdata[7:0];
        REG_RD_SAMPLE:   cfg.read_sample_tick     <= pwdata[7:0];
        REG_RD_SLOT:     cfg.read_slot_ticks      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RESET_LOW:   prdata = {22'd0, cfg.reset_low_ticks};
      REG_PRES_POLL:   prdata = {22'd0, cfg.presence_poll_ticks};
      REG_WR_ONE_LOW:  prdata = {24'd0, cfg.write_one_low_ticks};
      REG_WR_ZERO_LOW: prdata = {24'd0, cfg.write_zero_low_ticks};
      REG_WR_SLOT:     prdata = {24'd0, cfg.write_slot_ticks};
      REG_RD_LOW:      prdata = {24'd0, cfg.read_low_ticks};
      REG_RD_SAMPLE:   prdata = {24'd0, cfg.read_sample_tick};
      REG_RD_SLOT:     prdata = {24'd0, cfg.read_slot_ticks};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

/* src/one_wire_bus_master.sv */
// ----------------------------------------------------------------------------
// one_wire_bus_master: 1-Wire bus master with reset, byte write and byte read
// The result of a tick request appears in the output register in the cycle
// after the request is accepted.
// Throughput: one tick request per cycle unless the receiver stalls; a new
// request is taken as the last result leaves, set by the single result register.
// Reset (rst, synchronous): sequencer idle, timer, bit counter and byte
// registers cleared, timing registers back to their defaults, output empty.
// ----------------------------------------------------------------------------
module one_wire_bus_master
  import owm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Tick request channel.
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           mode,
  input  logic [7:0]           data_byte,
  input  logic                 line_sample,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 drive_low,
  output logic                 busy_res,
  output logic                 done_res,
  output logic                 presence_seen,
  output logic [7:0]           received_byte,
  output logic                 command_rejected,
  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  cfg_t cfg;

  owm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer state. It advances once per accepted tick request.
  phase_t                phase, phase_next;
  logic [TIMER_BITS-1:0] slot_timer, slot_timer_next;
  logic [2:0]            bit_index, bit_index_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic                  presence_flag, presence_flag_next;
  logic [7:0]            read_result, read_result_next;

  // The request is taken whenever the result register is empty or is being
  // emptied in this same cycle.
  logic in_fire;
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // A command only starts from idle; otherwise it is flagged and the tick
  // runs on as usual. The start tick is the first tick of the operation, so
  // the rest of the logic works on the state as the command leaves it.
  logic                  cmd_given, cmd_start, rejected;
  phase_t                eff_phase;
  logic [TIMER_BITS-1:0] eff_timer;
  logic [2:0]            eff_bit;
  logic [7:0]            eff_shift;

  assign cmd_given = (mode != MODE_TICK);
  assign cmd_start = cmd_given && (phase == PH_IDLE);
  assign rejected  = cmd_given && (phase != PH_IDLE);

  always_comb begin
    eff_phase = phase;
    eff_timer = slot_timer;
    eff_bit   = bit_index;
    eff_shift = shift_byte;
    if (cmd_start) begin
      eff_timer = '0;
      eff_bit   = '0;
      case (mode)
        MODE_RESET: eff_phase = PH_RLOW;
        MODE_WRITE: begin
          eff_phase = PH_WRITE;
          eff_shift = data_byte;
        end
        MODE_READ: begin
          eff_phase = PH_READ;
          eff_shift = 8'd0;
        end
        default: eff_phase = phase;
      endcase
    end
  end

  // Phase length for the running phase, then one shared increment and
  // compare. A length of zero ends the phase after its first tick, which is
  // what the compare gives naturally.
  logic [LEN_BITS-1:0]   phase_len;
  logic [TIMER_BITS:0]   timer_inc;
  logic                  phase_end;
  logic [TIMER_BITS-1:0] timer_adv;

  always_comb begin
    case (eff_phase)
      PH_RLOW:  phase_len = cfg.reset_low_ticks;
      PH_RGAP:  phase_len = RELEASE_WAIT;
      PH_RPOLL: phase_len = cfg.presence_poll_ticks;
      PH_WRITE: phase_len = LEN_BITS'(cfg.write_slot_ticks);
      PH_READ:  phase_len = LEN_BITS'(cfg.read_slot_ticks);
      default:  phase_len = '0;
    endcase
  end

  assign timer_inc = {1'b0, eff_timer} + (TIMER_BITS+1)'(1);
  assign phase_end = (CMP_W'(timer_inc) >= CMP_W'(phase_len)) ||
                     (timer_inc >= {1'b0, TIMER_MAX});
  assign timer_adv = phase_end ? '0 : timer_inc[TIMER_BITS-1:0];

  // Low pulse lengths: zero acts as one. A pulse at least as long as its
  // slot simply keeps the line low for the whole slot.
  logic [7:0] wr_low_raw, wr_low, rd_low;
  logic       in_low_wr, in_low_rd, sample_hit;
  logic [7:0] rd_shift;

  assign wr_low_raw = eff_shift[0] ? cfg.write_one_low_ticks : cfg.write_zero_low_ticks;
  assign wr_low     = (wr_low_raw == 8'd0) ? 8'd1 : wr_low_raw;
  assign rd_low     = (cfg.read_low_ticks == 8'd0) ? 8'd1 : cfg.read_low_ticks;
  assign in_low_wr  = CMP_W'(eff_timer) < CMP_W'(wr_low);
  assign in_low_rd  = CMP_W'(eff_timer) < CMP_W'(rd_low);
  // A sample tick beyond the slot never matches, so that bit reads as zero.
  assign sample_hit = (CMP_W'(eff_timer) == CMP_W'(cfg.read_sample_tick)) && line_sample;

  // Read bits enter at the top; the byte makes room at the start of a slot.
  always_comb begin
    rd_shift = (eff_timer == '0) ? {1'b0, eff_shift[7:1]} : eff_shift;
    if (sample_hit) begin
      rd_shift[7] = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    phase_next         = eff_phase;
    slot_timer_next    = eff_timer;
    bit_index_next     = eff_bit;
    shift_byte_next    = eff_shift;
    presence_flag_next = presence_flag;
    read_result_next   = read_result;
    case (eff_phase)
      PH_IDLE: ;
      PH_RLOW: begin
        slot_timer_next = timer_adv;
        if (phase_end) begin
          phase_next = PH_RGAP;
        end
      end
      PH_RGAP: begin
        slot_timer_next = timer_adv;
        if (phase_end) begin
          if (cfg.presence_poll_ticks == '0) begin
            presence_flag_next = 1'b0;
            phase_next         = PH_IDLE;
          end else begin
            phase_next = PH_RPOLL;
          end
        end
      end
      PH_RPOLL: begin
        if (!line_sample) begin
          slot_timer_next = '0;
          phase_next      = PH_RHOLD;
        end else begin
          slot_timer_next = timer_adv;
          if (phase_end) begin
            presence_flag_next = 1'b0;
            phase_next         = PH_IDLE;
          end
        end
      end
      PH_RHOLD: begin
        // A device holding the line low keeps the block here indefinitely.
        if (line_sample) begin
          presence_flag_next = 1'b1;
          phase_next         = PH_IDLE;
        end
      end
      PH_WRITE: begin
        slot_timer_next = timer_adv;
        if (phase_end) begin
          shift_byte_next = {1'b0, eff_shift[7:1]};
          if (eff_bit == 3'd7) begin
            bit_index_next = '0;
            phase_next     = PH_IDLE;
          end else begin
            bit_index_next = eff_bit + 3'd1;
          end
        end
      end
      PH_READ: begin
        slot_timer_next = timer_adv;
        shift_byte_next = rd_shift;
        if (phase_end) begin
          if (eff_bit == 3'd7) begin
            bit_index_next   = '0;
            read_result_next = rd_shift;
            phase_next       = PH_IDLE;
          end else begin
            bit_index_next = eff_bit + 3'd1;
          end
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // Per-tick outputs.
  logic drive_now, done_now;

  always_comb begin
    drive_now = 1'b0;
    case (eff_phase)
      PH_RLOW:  drive_now = 1'b1;
      PH_WRITE: drive_now = in_low_wr;
      PH_READ:  drive_now = in_low_rd;
      default:  drive_now = 1'b0;
    endcase
    // An operation completes on the tick that it falls back to idle.
    done_now = (eff_phase inside {PH_RLOW, PH_RGAP, PH_RPOLL, PH_RHOLD, PH_WRITE, PH_READ})
               && (phase_next == PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      slot_timer    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      presence_flag <= 1'b0;
      read_result   <= '0;
    end else if (in_fire) begin
      phase         <= phase_next;
      slot_timer    <= slot_timer_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      presence_flag <= presence_flag_next;
      read_result   <= read_result_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      drive_low        <= drive_now;
      busy_res         <= (phase_next != PH_IDLE);
      done_res         <= done_now;
      presence_seen    <= presence_flag_next;
      received_byte    <= read_result_next;
      command_rejected <= rejected;
    end
  end

  // Idle always leaves the timer and bit counter cleared for the next start.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (slot_timer == '0 && bit_index == '0))
    else $error("idle sequencer with stale timer or bit count");

  // A command seen while busy is flagged in its result.
  a_reject: assert property (@(posedge clk) disable iff (rst)
    (in_fire && mode != MODE_TICK && phase != PH_IDLE) |=> (out_valid && command_rejected))
    else $error("busy command not flagged");

  // A bus reset pulls the line low on its first tick.
  a_reset_drive: assert property (@(posedge clk) disable iff (rst)
    (in_fire && mode == MODE_RESET && phase == PH_IDLE) |=> (drive_low && busy_res))
    else $error("bus reset did not drive the line");

  // Completion and busy never appear together.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> !busy_res)
    else $error("done reported while still busy");

endmodule

/* test/tb_one_wire_bus_master.sv */
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master: self-checking testbench of the 1-Wire bus master
// Sends tick requests through the valid/ready request channel, checks every
// result against an in-bench model of the sequencer, and steps through
// several timing register settings over the APB port, from all zeros to long
// reset and poll lengths, under four mixes of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master
  import owm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // A correct run sends about two thousand tick requests: a few hundred of
  // directed traffic at short timings, one phase with a long reset and poll
  // (under a thousand ticks per operation), and short random phases. Even
  // with both sides throttling and the register traffic it stays far below
  // the limit, which leaves a wide margin.
  localparam int CYCLE_LIMIT = 200_000;
  localparam int NUM_PHASES  = 8;
  localparam int NUM_DIR     = 17;
  localparam int TIMING_DEFAULT [NUM_REGS] = '{480, 100, 6, 60, 70, 2, 7, 87};

  // One result of one tick request, in port order.
  typedef struct packed {
    logic       drive;
    logic       busy;
    logic       done;
    logic       presence;
    logic [7:0] rx;
    logic       rejected;
  } tick_result_t;

  // One row of the directed table. When typed is set the row carries its own
  // expected result; run_out lets the operation finish with a simulated
  // device answering on the bus.
  typedef struct packed {
    mode_t        m;
    logic [7:0]   d;
    logic         lvl;
    logic         typed;
    tick_result_t res;
    logic         run_out;
    logic         dev_here;
    logic [7:0]   dev_byte;
    logic [8:0]   hold_len;
  } stim_row_t;

  localparam tick_result_t IDLE_RES   = '0;
  localparam tick_result_t RLOW_RES   = '{drive: 1'b1, busy: 1'b1, default: '0};
  localparam tick_result_t REJECT_RES = '{drive: 1'b1, busy: 1'b1, rejected: 1'b1,
                                          default: '0};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           mode = MODE_TICK;
  logic [7:0]           data_byte = 8'h00;
  logic                 line_sample = 1'b1;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 drive_low;
  logic                 busy_res;
  logic                 done_res;
  logic                 presence_seen;
  logic [7:0]           received_byte;
  logic                 command_rejected;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  one_wire_bus_master dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .mode             (mode),
    .data_byte        (data_byte),
    .line_sample      (line_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .drive_low        (drive_low),
    .busy_res         (busy_res),
    .done_res         (done_res),
    .presence_seen    (presence_seen),
    .received_byte    (received_byte),
    .command_rejected (command_rejected),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sequencer model: its own copy of the timing registers and the state.
  int           timing_reg [NUM_REGS];
  int           next_timing [NUM_REGS];
  phase_t       bus_phase;
  int           slot_count;
  int           bit_pos;
  logic [7:0]   shift_reg;
  logic         presence_reg;
  logic [7:0]   rx_reg;

  // Results the block still owes, oldest first.
  tick_result_t pending_results [$];
  tick_result_t head_res;

  // Simulated device on the bus, used to shape line_sample.
  bit           dev_present;
  int           pres_delay;
  int           pres_len;
  int           hold_ticks;
  logic [7:0]   dev_byte;

  // Traffic shaping knobs.
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           line_noise_pct = 0;
  int           busy_cmd_pct = 0;

  int           error_count = 0;
  int           cycle_count = 0;
  int           items_sent = 0;
  int           results_checked = 0;
  int           resets_started = 0;
  int           writes_started = 0;
  int           reads_started = 0;
  int           presence_found = 0;
  int           rejects_seen = 0;
  mode_t        last_op = MODE_TICK;

  stim_row_t    dir_rows [NUM_DIR];

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Advances the slot timer; returns 1 when a phase of length lim is over.
  // The timer also gives up at its largest value, whatever lim says.
  function automatic bit slot_elapsed(int lim);
    int nxt;
    nxt = slot_count + 1;
    if (nxt >= lim || nxt >= int'(TIMER_MAX)) begin
      slot_count = 0;
      return 1'b1;
    end
    slot_count = nxt;
    return 1'b0;
  endfunction

  // Works out the result of one tick and moves the model state on.
  function automatic tick_result_t predict_tick(mode_t m, logic [7:0] d, logic lvl);
    tick_result_t r;
    int low_len;
    r = '0;
    // A command is taken only while idle; otherwise it is flagged and the
    // tick runs as a plain tick.
    if (m != MODE_TICK) begin
      if (bus_phase != PH_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        slot_count = 0;
        bit_pos = 0;
        case (m)
          MODE_RESET: bus_phase = PH_RLOW;
          MODE_WRITE: begin
            bus_phase = PH_WRITE;
            shift_reg = d;
          end
          default: begin
            bus_phase = PH_READ;
            shift_reg = '0;
          end
        endcase
      end
    end
    case (bus_phase)
      PH_RLOW: begin
        r.drive = 1'b1;
        if (slot_elapsed(timing_reg[REG_RESET_LOW])) bus_phase = PH_RGAP;
      end
      PH_RGAP: begin
        if (slot_elapsed(int'(RELEASE_WAIT))) begin
          // A zero poll length ends the reset right here with no presence.
          if (timing_reg[REG_PRES_POLL] == 0) begin
            presence_reg = 1'b0;
            bus_phase = PH_IDLE;
            r.done = 1'b1;
          end else begin
            bus_phase = PH_RPOLL;
          end
        end
      end
      PH_RPOLL: begin
        if (!lvl) begin
          slot_count = 0;
          bus_phase = PH_RHOLD;
        end else if (slot_elapsed(timing_reg[REG_PRES_POLL])) begin
          presence_reg = 1'b0;
          bus_phase = PH_IDLE;
          r.done = 1'b1;
        end
      end
      PH_RHOLD: begin
        // Waits for the device to let go, with no time limit.
        if (lvl) begin
          presence_reg = 1'b1;
          bus_phase = PH_IDLE;
          r.done = 1'b1;
        end
      end
      PH_WRITE: begin
        low_len = shift_reg[0] ? timing_reg[REG_WR_ONE_LOW] : timing_reg[REG_WR_ZERO_LOW];
        if (low_len == 0) low_len = 1;
        r.drive = (slot_count < low_len);
        if (slot_elapsed(timing_reg[REG_WR_SLOT])) begin
          shift_reg = shift_reg >> 1;
          if (bit_pos >= 7) begin
            bit_pos = 0;
            bus_phase = PH_IDLE;
            r.done = 1'b1;
          end else begin
            bit_pos++;
          end
        end
      end
      PH_READ: begin
        low_len = (timing_reg[REG_RD_LOW] == 0) ? 1 : timing_reg[REG_RD_LOW];
        if (slot_count == 0) shift_reg = shift_reg >> 1;
        r.drive = (slot_count < low_len);
        // A sample tick outside the slot is never reached, so the bit stays 0.
        if (slot_count == timing_reg[REG_RD_SAMPLE] && lvl) shift_reg[7] = 1'b1;
        if (slot_elapsed(timing_reg[REG_RD_SLOT])) begin
          if (bit_pos >= 7) begin
            bit_pos = 0;
            rx_reg = shift_reg;
            bus_phase = PH_IDLE;
            r.done = 1'b1;
          end else begin
            bit_pos++;
          end
        end
      end
      default: bus_phase = PH_IDLE;
    endcase
    r.busy = (bus_phase != PH_IDLE);
    r.presence = presence_reg;
    r.rx = rx_reg;
    return r;
  endfunction

  // Bus level that the simulated device produces for the next tick, given
  // what the master is doing. A little noise flips it now and then.
  function automatic logic bus_level();
    logic lvl;
    case (bus_phase)
      PH_RPOLL: lvl = !(dev_present && slot_count >= pres_delay);
      PH_RHOLD: lvl = (hold_ticks >= pres_len);
      PH_READ:  lvl = dev_byte[bit_pos];
      default:  lvl = chance(80);
    endcase
    if (chance(line_noise_pct)) lvl = !lvl;
    return lvl;
  endfunction

  // Offers one tick request, waits for it to be taken and records what the
  // block must answer. Called right after a rising edge.
  task automatic send_tick(input mode_t m, input logic [7:0] d, input logic lvl,
                           input bit typed, input tick_result_t typed_res);
    tick_result_t pred;
    while (chance(send_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    data_byte   <= d;
    line_sample <= lvl;
    do @(posedge clk); while (!in_ready);
    pred = predict_tick(m, d, lvl);
    // Typed rows are checked against the value written in the table; the
    // model still runs on them so that its state stays in step.
    pending_results.push_back(typed ? typed_res : pred);
    items_sent++;
    if (bus_phase == PH_RHOLD) hold_ticks++;
    else hold_ticks = 0;
    if (pred.rejected) begin
      rejects_seen++;
    end else if (m != MODE_TICK) begin
      last_op = m;
      case (m)
        MODE_RESET: resets_started++;
        MODE_WRITE: writes_started++;
        default:    reads_started++;
      endcase
    end
    if (pred.done && last_op == MODE_RESET && pred.presence) presence_found++;
  endtask

  // Keeps ticking until the model says the operation has finished. Some
  // commands thrown in on the way must bounce off as rejected.
  task automatic run_to_idle();
    while (bus_phase != PH_IDLE) begin
      if (chance(busy_cmd_pct))
        send_tick(mode_t'($urandom_range(1, 3)), 8'($urandom), bus_level(), 1'b0, '0);
      else
        send_tick(MODE_TICK, 8'($urandom), bus_level(), 1'b0, '0);
    end
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // One APB transfer: a setup cycle, then access until pready.
  task automatic apb_xfer(input bit wr, input int idx, input int val,
                          output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_BITS'(4 * idx);
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes every timing register, reads it back and updates the model.
  task automatic load_timing();
    logic [31:0] rd;
    int          want;
    for (int i = 0; i < NUM_REGS; i++) begin
      want = next_timing[i] & ((i <= REG_PRES_POLL) ? 32'h3FF : 32'hFF);
      apb_xfer(1'b1, i, next_timing[i], rd);
      apb_xfer(1'b0, i, 0, rd);
      if (rd !== 32'(want)) begin
        $error("timing register %0d readback mismatch: expected %0d, actual %0d",
               i, want, rd);
        error_count++;
      end
      timing_reg[i] = want;
    end
  endtask

  task automatic set_timing(input int rl, input int pp, input int w1, input int w0,
                            input int ws, input int rlo, input int rs, input int rsl);
    next_timing[REG_RESET_LOW]   = rl;
    next_timing[REG_PRES_POLL]   = pp;
    next_timing[REG_WR_ONE_LOW]  = w1;
    next_timing[REG_WR_ZERO_LOW] = w0;
    next_timing[REG_WR_SLOT]     = ws;
    next_timing[REG_RD_LOW]      = rlo;
    next_timing[REG_RD_SAMPLE]   = rs;
    next_timing[REG_RD_SLOT]     = rsl;
  endtask

  // Picks the timing setting of one random phase. Most settings are short so
  // that many operations fit; one phase runs long reset and poll lengths.
  task automatic choose_timing(input int idx);
    for (int i = 0; i < NUM_REGS; i++) next_timing[i] = $urandom_range(0, 12);
    case (idx)
      0: set_timing(8, 6, 1, 5, 7, 1, 3, 6);
      // Every length at zero acts as one tick; a zero poll skips presence.
      1: set_timing(0, 0, 0, 0, 0, 0, 0, 0);
      // Low pulses longer than their slots, and a sample tick past the slot.
      2: set_timing(3, 1, 9, 12, 8, 10, 6, 6);
      // Reset and poll lengths that reach the upper register bits, with the
      // largest low pulses and sample tick against short slots.
      3: set_timing(600, 260, 255, 255, 24, 255, 255, 20);
      5: next_timing[REG_PRES_POLL] = 0;
      6: set_timing(20, 15, 3, 10, 12, 2, 5, 10);
      default: ;
    endcase
  endtask

  // A well-formed operation: fresh device behavior, one command, then ticks
  // until it completes.
  task automatic run_op();
    dev_present = chance(75);
    pres_delay  = $urandom_range(0, timing_reg[REG_PRES_POLL] + 1);
    pres_len    = chance(5) ? $urandom_range(100, 300) : $urandom_range(0, 12);
    dev_byte    = 8'($urandom);
    send_tick(mode_t'($urandom_range(1, 3)), 8'($urandom), bus_level(), 1'b0, '0);
    run_to_idle();
  endtask

  task automatic check_field(input string fname, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", fname, want, got);
      error_count++;
    end
  endtask

  // Receiver side: random stalls, and the check of every taken result.
  always @(posedge clk) begin
    out_ready <= !chance(recv_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result taken while none was pending");
        error_count++;
      end else begin
        head_res = pending_results.pop_front();
        check_field("drive_low", {7'd0, head_res.drive}, {7'd0, drive_low});
        check_field("busy_res", {7'd0, head_res.busy}, {7'd0, busy_res});
        check_field("done_res", {7'd0, head_res.done}, {7'd0, done_res});
        check_field("presence_seen", {7'd0, head_res.presence}, {7'd0, presence_seen});
        check_field("received_byte", head_res.rx, received_byte);
        check_field("command_rejected", {7'd0, head_res.rejected},
                    {7'd0, command_rejected});
        results_checked++;
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("one_wire_bus_master test failed");
      $finish;
    end
  end

  initial begin
    stim_row_t   row;
    int          budget;
    int          start_items;
    logic [31:0] rd;

    // Directed table, run at short timings. The first rows are easy to read
    // off: plain ticks while idle, a reset start, and commands bounced while
    // the reset low pulse is running.
    dir_rows[0]  = '{MODE_TICK,  8'h00, 1'b1, 1'b1, IDLE_RES,   1'b0, 1'b0, 8'h00, 9'd0};
    dir_rows[1]  = '{MODE_TICK,  8'hFF, 1'b0, 1'b1, IDLE_RES,   1'b0, 1'b0, 8'h00, 9'd0};
    dir_rows[2]  = '{MODE_RESET, 8'h00, 1'b1, 1'b1, RLOW_RES,   1'b0, 1'b0, 8'h00, 9'd0};
    dir_rows[3]  = '{MODE_WRITE, 8'hA5, 1'b0, 1'b1, REJECT_RES, 1'b0, 1'b0, 8'h00, 9'd0};
    dir_rows[4]  = '{MODE_READ,  8'hFF, 1'b1, 1'b1, REJECT_RES, 1'b0, 1'b0, 8'h00, 9'd0};
    // No device on the bus: the poll runs out.
    dir_rows[5]  = '{MODE_RESET, 8'h00, 1'b1, 1'b1, REJECT_RES, 1'b1, 1'b0, 8'h00, 9'd0};
    dir_rows[6]  = '{MODE_RESET, 8'h00, 1'b1, 1'b0, IDLE_RES,   1'b1, 1'b1, 8'h00, 9'd8};
    dir_rows[7]  = '{MODE_WRITE, 8'h00, 1'b1, 1'b0, IDLE_RES,   1'b0, 1'b0, 8'h00, 9'd0};
    dir_rows[8]  = '{MODE_READ,  8'h00, 1'b1, 1'b0, IDLE_RES,   1'b1, 1'b0, 8'h00, 9'd0};
    dir_rows[9]  = '{MODE_WRITE, 8'hFF, 1'b0, 1'b0, IDLE_RES,   1'b1, 1'b0, 8'h00, 9'd0};
    dir_rows[10] = '{MODE_WRITE, 8'h5A, 1'b1, 1'b0, IDLE_RES,   1'b1, 1'b0, 8'h00, 9'd0};
    dir_rows[11] = '{MODE_READ,  8'h00, 1'b1, 1'b0, IDLE_RES,   1'b1, 1'b0, 8'hFF, 9'd0};
    dir_rows[12] = '{MODE_READ,  8'h00, 1'b0, 1'b0, IDLE_RES,   1'b1, 1'b0, 8'h00, 9'd0};
    dir_rows[13] = '{MODE_READ,  8'hFF, 1'b1, 1'b0, IDLE_RES,   1'b1, 1'b0, 8'hC3, 9'd0};
    // The device holds its presence pulse far longer than usual.
    dir_rows[14] = '{MODE_RESET, 8'h00, 1'b1, 1'b0, IDLE_RES,   1'b1, 1'b1, 8'h00, 9'd150};
    dir_rows[15] = '{MODE_TICK,  8'h00, 1'b1, 1'b0, IDLE_RES,   1'b0, 1'b0, 8'h00, 9'd0};
    dir_rows[16] = '{MODE_TICK,  8'hFF, 1'b0, 1'b0, IDLE_RES,   1'b0, 1'b0, 8'h00, 9'd0};

    for (int i = 0; i < NUM_REGS; i++) timing_reg[i] = TIMING_DEFAULT[i];
    bus_phase    = PH_IDLE;
    slot_count   = 0;
    bit_pos      = 0;
    shift_reg    = '0;
    presence_reg = 1'b0;
    rx_reg       = '0;
    hold_ticks   = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The timing registers come out of reset at their defaults.
    for (int i = 0; i < NUM_REGS; i++) begin
      apb_xfer(1'b0, i, 0, rd);
      if (rd !== 32'(TIMING_DEFAULT[i])) begin
        $error("timing register %0d reset value mismatch: expected %0d, actual %0d",
               i, TIMING_DEFAULT[i], rd);
        error_count++;
      end
    end

    // Short timings keep each directed operation to a few dozen ticks.
    set_timing(8, 6, 1, 5, 7, 1, 3, 6);
    load_timing();

    for (int k = 0; k < NUM_DIR; k++) begin
      row = dir_rows[k];
      dev_present = row.dev_here;
      dev_byte    = row.dev_byte;
      pres_len    = row.hold_len;
      pres_delay  = 5;
      send_tick(row.m, row.d, row.lvl, row.typed, row.res);
      if (row.run_out) run_to_idle();
    end

    // Random phases. Each one lets the block settle, loads a new timing
    // setting while nothing is in flight, and picks an idling mix.
    line_noise_pct = 3;
    busy_cmd_pct   = 4;
    for (int p = 0; p < NUM_PHASES; p++) begin
      run_to_idle();
      wait_for_results();
      repeat (2) @(posedge clk);
      choose_timing(p);
      load_timing();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      budget = (p == 3) ? 100 : 90;
      start_items = items_sent;
      while (items_sent - start_items < budget) begin
        if (chance(2)) wait_for_results();
        if (bus_phase == PH_IDLE && chance(85)) begin
          repeat ($urandom_range(0, 2))
            send_tick(MODE_TICK, 8'($urandom), bus_level(), 1'b0, '0);
          run_op();
        end else begin
          // Loose requests: any mode, any line level, in or out of an
          // operation.
          send_tick(chance(60) ? MODE_TICK : mode_t'($urandom_range(1, 3)),
                    8'($urandom), 1'($urandom_range(1)), 1'b0, '0);
        end
      end
    end

    run_to_idle();
    wait_for_results();
    repeat (8) @(posedge clk);

    $display("Checked %0d results of %0d tick requests over %0d timing settings.",
             results_checked, items_sent, NUM_PHASES + 1);
    $display("Started %0d resets (%0d with presence), %0d writes, %0d reads; %0d rejected.",
             resets_started, presence_found, writes_started, reads_started, rejects_seen);
    if (error_count == 0)
      $display("one_wire_bus_master test passed");
    else
      $display("one_wire_bus_master test failed");
    $finish;
  end

endmodule
